// File: rtl/core/sc2a_pkg.sv
// package: types, constants and keymap lookup for the scancode to ascii buffer
package sc2a_pkg;

    localparam int DEPTH  = 256;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = PTR_W + 1;
    localparam int PEND_W = (CNT_W > 8) ? CNT_W : 8;

    localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
    localparam logic [7:0] SC_BREAK_BIT    = 8'h80;
    localparam logic [7:0] SC_TABLE_SIZE   = 8'h3A;
    localparam logic [6:0] CASE_OFFSET     = 7'd32;
    localparam logic [6:0] CH_LOWER_A      = 7'h61;
    localparam logic [6:0] CH_LOWER_Z      = 7'h7A;

    localparam logic ACT_SCANCODE = 1'b0;
    localparam logic ACT_READ     = 1'b1;

    localparam int          PEND_FULL_I = DEPTH - 1;
    localparam int          PEND_SAT_I  = (PEND_FULL_I > 255) ? 255 : PEND_FULL_I;
    localparam logic [7:0]  PEND_SAT    = 8'(PEND_SAT_I);

    typedef struct packed {
        logic       action;
        logic [7:0] scancode;
    } t_sc2a_in;

    typedef struct packed {
        logic [6:0] read_char;
        logic       read_valid;
        logic       dropped;
        logic [7:0] pending;
    } t_sc2a_out;

    function automatic logic [6:0] us_layout(input logic [5:0] idx);
        logic [6:0] ch;
        case (idx)
            6'd1:    ch = 7'h1B;
            6'd2:    ch = 7'h31;
            6'd3:    ch = 7'h32;
            6'd4:    ch = 7'h33;
            6'd5:    ch = 7'h34;
            6'd6:    ch = 7'h35;
            6'd7:    ch = 7'h36;
            6'd8:    ch = 7'h37;
            6'd9:    ch = 7'h38;
            6'd10:   ch = 7'h39;
            6'd11:   ch = 7'h30;
            6'd12:   ch = 7'h2D;
            6'd13:   ch = 7'h3D;
            6'd14:   ch = 7'h08;
            6'd15:   ch = 7'h09;
            6'd16:   ch = 7'h71;
            6'd17:   ch = 7'h77;
            6'd18:   ch = 7'h65;
            6'd19:   ch = 7'h72;
            6'd20:   ch = 7'h74;
            6'd21:   ch = 7'h79;
            6'd22:   ch = 7'h75;
            6'd23:   ch = 7'h69;
            6'd24:   ch = 7'h6F;
            6'd25:   ch = 7'h70;
            6'd26:   ch = 7'h5B;
            6'd27:   ch = 7'h5D;
            6'd28:   ch = 7'h0A;
            6'd30:   ch = 7'h61;
            6'd31:   ch = 7'h73;
            6'd32:   ch = 7'h64;
            6'd33:   ch = 7'h66;
            6'd34:   ch = 7'h67;
            6'd35:   ch = 7'h68;
            6'd36:   ch = 7'h6A;
            6'd37:   ch = 7'h6B;
            6'd38:   ch = 7'h6C;
            6'd39:   ch = 7'h3B;
            6'd40:   ch = 7'h27;
            6'd41:   ch = 7'h60;
            6'd43:   ch = 7'h5C;
            6'd44:   ch = 7'h7A;
            6'd45:   ch = 7'h78;
            6'd46:   ch = 7'h63;
            6'd47:   ch = 7'h76;
            6'd48:   ch = 7'h62;
            6'd49:   ch = 7'h6E;
            6'd50:   ch = 7'h6D;
            6'd51:   ch = 7'h2C;
            6'd52:   ch = 7'h2E;
            6'd53:   ch = 7'h2F;
            6'd55:   ch = 7'h2A;
            6'd57:   ch = 7'h20;
            default: ch = 7'h00;
        endcase
        return ch;
    endfunction

endpackage

// File: rtl/core/scancode_to_ascii_fifo.sv
// top level: ps/2 set-1 scancode translator with a character ring buffer
//
//  channel   ports                       transfer
//  input     start, busy, i_item         edge with start high and busy low
//  output    o_strobe, o_result          edge that ends the strobe cycle
//
// for each item, the accept edge reads the buffer slot at the read
// pointer from the synchronous memory, the next edge writes back, moves the
// pointers and registers the result, which shows for one cycle with o_strobe
// busy is high during the cycle between accept and result
// reset clears the shift flag, both pointers and the handshake flags only
// the receiver cannot stall, so a new item may be accepted while a result shows
module scancode_to_ascii_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  sc2a_pkg::t_sc2a_in  i_item,
    output logic                o_strobe,
    output sc2a_pkg::t_sc2a_out o_result
);

    logic [6:0] r_mem [sc2a_pkg::DEPTH];

    logic                           r_busy;
    logic                           r_strobe;
    logic                           r_shift;
    logic [sc2a_pkg::PTR_W-1:0]     r_wr_ptr;
    logic [sc2a_pkg::PTR_W-1:0]     r_rd_ptr;
    sc2a_pkg::t_sc2a_in             r_item;
    logic [6:0]                     r_rd_data;
    sc2a_pkg::t_sc2a_out            r_result;

    logic                           n_shift;
    logic [sc2a_pkg::PTR_W-1:0]     n_wr_ptr;
    logic [sc2a_pkg::PTR_W-1:0]     n_rd_ptr;
    sc2a_pkg::t_sc2a_out            n_result;

    logic                           w_accept;
    logic [6:0]                     w_map;
    logic [6:0]                     w_char;
    logic                           w_in_table;
    logic                           w_push;
    logic                           w_full;
    logic                           w_empty;
    logic [sc2a_pkg::PTR_W-1:0]     w_wr_adv;
    logic [sc2a_pkg::PTR_W-1:0]     w_rd_adv;
    logic [sc2a_pkg::PEND_W-1:0]    w_cnt;

    assign w_accept = start && !r_busy;
    assign busy     = r_busy;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    assign w_wr_adv = (r_wr_ptr == sc2a_pkg::PTR_W'(sc2a_pkg::DEPTH - 1))
                    ? '0 : r_wr_ptr + 1'b1;
    assign w_rd_adv = (r_rd_ptr == sc2a_pkg::PTR_W'(sc2a_pkg::DEPTH - 1))
                    ? '0 : r_rd_ptr + 1'b1;
    assign w_full   = (w_wr_adv == r_rd_ptr);
    assign w_empty  = (r_wr_ptr == r_rd_ptr);

    assign w_in_table = ((r_item.scancode & sc2a_pkg::SC_BREAK_BIT) == 8'h00)
                     && (r_item.scancode < sc2a_pkg::SC_TABLE_SIZE);
    assign w_map      = sc2a_pkg::us_layout(r_item.scancode[5:0]);
    assign w_char     = (r_shift && w_map >= sc2a_pkg::CH_LOWER_A
                                 && w_map <= sc2a_pkg::CH_LOWER_Z)
                      ? w_map - sc2a_pkg::CASE_OFFSET : w_map;

    always_comb begin
        n_shift             = r_shift;
        n_wr_ptr            = r_wr_ptr;
        n_rd_ptr            = r_rd_ptr;
        w_push              = 1'b0;
        n_result.read_char  = 7'h00;
        n_result.read_valid = 1'b0;
        n_result.dropped    = 1'b0;
        case (r_item.action)
            sc2a_pkg::ACT_SCANCODE: begin
                if (r_item.scancode == sc2a_pkg::SC_LSHIFT_MAKE
                    || r_item.scancode == sc2a_pkg::SC_RSHIFT_MAKE) begin
                    n_shift = 1'b1;
                end else if (r_item.scancode == sc2a_pkg::SC_LSHIFT_BREAK
                    || r_item.scancode == sc2a_pkg::SC_RSHIFT_BREAK) begin
                    n_shift = 1'b0;
                end else if (w_in_table && w_map != 7'h00) begin
                    if (w_full) begin
                        n_result.dropped = 1'b1;
                    end else begin
                        w_push   = 1'b1;
                        n_wr_ptr = w_wr_adv;
                    end
                end
            end
            sc2a_pkg::ACT_READ: begin
                if (!w_empty) begin
                    n_result.read_char  = r_rd_data;
                    n_result.read_valid = 1'b1;
                    n_rd_ptr            = w_rd_adv;
                end
            end
            default: begin
                n_shift = r_shift;
            end
        endcase
        if (n_wr_ptr >= n_rd_ptr) begin
            w_cnt = sc2a_pkg::PEND_W'(n_wr_ptr) - sc2a_pkg::PEND_W'(n_rd_ptr);
        end else begin
            w_cnt = sc2a_pkg::PEND_W'(n_wr_ptr) + sc2a_pkg::PEND_W'(sc2a_pkg::DEPTH)
                  - sc2a_pkg::PEND_W'(n_rd_ptr);
        end
        n_result.pending = (w_cnt > sc2a_pkg::PEND_W'(255)) ? 8'hFF : w_cnt[7:0];
    end

    // buffer memory, one write in the busy cycle of a push and one registered read on accept
    always_ff @(posedge i_clk) begin
        if (r_busy && w_push) begin
            r_mem[r_wr_ptr] <= w_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_data <= r_mem[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
        if (r_busy) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
            r_shift  <= 1'b0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_busy   <= w_accept;
            r_strobe <= r_busy;
            if (r_busy) begin
                r_shift  <= n_shift;
                r_wr_ptr <= n_wr_ptr;
                r_rd_ptr <= n_rd_ptr;
            end
        end
    end

endmodule

// File: rtl/core/sc2a_checker.sv
// checker: port-level assertions for the scancode to ascii buffer, with bind
module sc2a_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input sc2a_pkg::t_sc2a_in  i_item,
    input logic                o_strobe,
    input sc2a_pkg::t_sc2a_out o_result
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_strobe))
        else $error("accepted transfer did not raise busy");

    a_busy_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (o_strobe && !busy))
        else $error("result did not follow busy");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_result.read_valid && o_result.dropped))
        else $error("read and drop in one result");

    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.read_valid) |-> (o_result.read_char == 7'h00))
        else $error("character without valid read");

    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.dropped) |-> (o_result.pending == sc2a_pkg::PEND_SAT))
        else $error("drop while buffer not full");

endmodule

bind scancode_to_ascii_fifo sc2a_checker u_sc2a_checker (.*);

// File: tb/sv/tb_scancode_to_ascii_fifo.sv
`timescale 1ns / 1ps
// testbench for scancode_to_ascii_fifo: keystrokes and reads checked against a predictor
module tb_scancode_to_ascii_fifo;
    import sc2a_pkg::*;

    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 10;
    localparam int SETTLE_LIMIT = 100000;
    localparam int CALM_TAIL    = 60;
    localparam int FILL_ITEMS   = 340;
    localparam int EMPTY_ITEMS  = 230;

    // us layout, set-1 make code to ascii, 0 = unmapped
    localparam logic [0:57][6:0] KEYMAP = {
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
        7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
        7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    logic      busy;
    t_sc2a_in  i_item  = '0;
    logic      o_strobe;
    t_sc2a_out o_result;

    logic       shift_down = 1'b0;
    int         wr_slot    = 0;
    int         rd_slot    = 0;
    logic [6:0] char_slots [DEPTH];

    t_sc2a_in   keystrokes_pending [$];
    t_sc2a_out  results_due [$];
    int         gap_left    = 0;
    int         error_count = 0;

    scancode_to_ascii_fifo u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_sc2a_out translate_and_buffer(input t_sc2a_in key);
        t_sc2a_out  res;
        logic [6:0] ch;
        int         nxt;
        int         held;
        res = '0;
        if (key.action == ACT_SCANCODE) begin
            if (key.scancode == SC_LSHIFT_MAKE || key.scancode == SC_RSHIFT_MAKE) begin
                shift_down = 1'b1;
            end else if (key.scancode == SC_LSHIFT_BREAK || key.scancode == SC_RSHIFT_BREAK) begin
                shift_down = 1'b0;
            end else if ((key.scancode & SC_BREAK_BIT) == 8'h00 &&
                         key.scancode < SC_TABLE_SIZE) begin
                ch = KEYMAP[key.scancode];
                if (ch != 7'h00) begin
                    if (shift_down && ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
                        ch = ch - CASE_OFFSET;
                    end
                    nxt = (wr_slot + 1) % DEPTH;
                    if (nxt != rd_slot) begin
                        char_slots[wr_slot] = ch;
                        wr_slot = nxt;
                    end else begin
                        res.dropped = 1'b1;
                    end
                end
            end
        end else if (wr_slot != rd_slot) begin
            res.read_char  = char_slots[rd_slot];
            res.read_valid = 1'b1;
            rd_slot = (rd_slot + 1) % DEPTH;
        end
        held = (wr_slot + DEPTH - rd_slot) % DEPTH;
        res.pending = (held > 255) ? 8'd255 : 8'(held);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic queue_key(input logic act, input logic [7:0] code);
        t_sc2a_in key;
        key.action   = act;
        key.scancode = code;
        keystrokes_pending.push_back(key);
    endtask

    function automatic t_sc2a_in random_keystroke(input int read_pct);
        t_sc2a_in key;
        int       pick;
        key.action   = ACT_SCANCODE;
        key.scancode = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < read_pct) begin
            key.action = ACT_READ;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 88) begin
                key.scancode = 8'($urandom_range(0, int'(SC_TABLE_SIZE) - 1));
            end else if (pick < 94) begin
                case ($urandom_range(0, 3))
                    0: key.scancode = SC_LSHIFT_MAKE;
                    1: key.scancode = SC_RSHIFT_MAKE;
                    2: key.scancode = SC_LSHIFT_BREAK;
                    default: key.scancode = SC_RSHIFT_BREAK;
                endcase
            end
        end
        return key;
    endfunction

    // sender: one transfer per edge at most, random idle bursts except in the tail
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            i_item   <= '0;
            gap_left <= 0;
        end else begin
            if (start && !busy) begin
                results_due.push_back(translate_and_buffer(i_item));
            end
            if (start && busy) begin
                // hold the item until it is taken
            end else if (gap_left > 0) begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (keystrokes_pending.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
                start    <= 1'b0;
                gap_left <= $urandom_range(0, 4);
            end else if (keystrokes_pending.size() > 0) begin
                start  <= 1'b1;
                i_item <= keystrokes_pending.pop_front();
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : watch
        t_sc2a_out want;
        if (i_rst_n && o_strobe) begin
            if (results_due.size() == 0) begin
                report_mismatch("unexpected result, pending", o_result.pending, 0);
            end else begin
                want = results_due.pop_front();
                if (o_result.read_char !== want.read_char)
                    report_mismatch("read_char", o_result.read_char, want.read_char);
                if (o_result.read_valid !== want.read_valid)
                    report_mismatch("read_valid", o_result.read_valid, want.read_valid);
                if (o_result.dropped !== want.dropped)
                    report_mismatch("dropped", o_result.dropped, want.dropped);
                if (o_result.pending !== want.pending)
                    report_mismatch("pending", o_result.pending, want.pending);
            end
        end
    end

    initial begin
        int w;
        queue_key(ACT_READ, 8'h00);
        queue_key(ACT_SCANCODE, 8'h1E);
        queue_key(ACT_SCANCODE, SC_LSHIFT_MAKE);
        queue_key(ACT_SCANCODE, 8'h1E);
        queue_key(ACT_SCANCODE, 8'h02);
        queue_key(ACT_SCANCODE, 8'h9E);
        queue_key(ACT_SCANCODE, SC_LSHIFT_BREAK);
        queue_key(ACT_SCANCODE, 8'h10);
        queue_key(ACT_SCANCODE, SC_RSHIFT_MAKE);
        queue_key(ACT_SCANCODE, 8'h2C);
        queue_key(ACT_SCANCODE, 8'h35);
        queue_key(ACT_SCANCODE, SC_RSHIFT_BREAK);
        queue_key(ACT_SCANCODE, 8'h2C);
        queue_key(ACT_SCANCODE, 8'h00);
        queue_key(ACT_SCANCODE, 8'h1D);
        queue_key(ACT_SCANCODE, SC_TABLE_SIZE);
        queue_key(ACT_SCANCODE, 8'h7F);
        queue_key(ACT_SCANCODE, 8'h80);
        queue_key(ACT_SCANCODE, 8'hFF);
        queue_key(ACT_SCANCODE, 8'h39);
        queue_key(ACT_SCANCODE, 8'h01);
        queue_key(ACT_READ, 8'hFF);
        queue_key(ACT_READ, 8'h2A);
        queue_key(ACT_READ, 8'h55);
        // mostly keystrokes until the buffer overflows, then mostly reads to drain it
        for (w = 0; w < FILL_ITEMS; w++) keystrokes_pending.push_back(random_keystroke(3));
        for (w = 0; w < EMPTY_ITEMS; w++) keystrokes_pending.push_back(random_keystroke(95));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (w = 0; w < SETTLE_LIMIT &&
             (keystrokes_pending.size() != 0 || start || results_due.size() != 0); w++)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (results_due.size() != 0)
            report_mismatch("results never seen", 0, results_due.size());

        if (error_count == 0) begin
            $display("scancode_to_ascii_fifo verification clean");
        end else begin
            $display("scancode_to_ascii_fifo verification failed");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("scancode_to_ascii_fifo verification failed");
        $finish;
    end

endmodule
